// ===== hw/rtl/smed_pkg.sv =====
// Shared types, constants and compare-exchange helpers for the 3x3 two-pixel median filter.
package smed_pkg;

  localparam int unsigned IMAGE_WIDTH = 128;
  localparam int unsigned HALF_WIDTH  = IMAGE_WIDTH / 2;
  localparam int unsigned LINE_DEPTH  = HALF_WIDTH - 2;
  localparam int unsigned PTR_W       = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned COL_W       = (HALF_WIDTH > 1) ? $clog2(HALF_WIDTH) : 1;
  localparam int unsigned PX_W        = 8;
  localparam int unsigned ROWS_W      = 13;
  localparam int unsigned NET_LAYERS  = 8;

  localparam logic [ROWS_W-1:0] ROWS_MIN   = 13'd3;
  localparam logic [ROWS_W-1:0] ROWS_MAX   = 13'd4096;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd128;
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(HALF_WIDTH - 1);

  typedef logic [PX_W-1:0]         px_t;
  typedef logic [8:0][PX_W-1:0]    set9_t;
  typedef logic [11:0][PX_W-1:0]   win_t;
  typedef logic [3:0]              lane_t;

  typedef enum logic {
    CMD_PIXELS = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_e;

  typedef enum logic {
    MODE_WAIT,
    MODE_RUN
  } mode_e;

  typedef struct packed {
    logic valid;
    logic last;
    logic pass_even;
    logic pass_odd;
  } slot_ctl_t;

  typedef struct packed {
    logic      step;
    logic      flush;
    slot_ctl_t slot;
  } ctrl_t;

  typedef struct packed {
    px_t   even_pass;
    px_t   odd_pass;
    set9_t odd_set;
    set9_t even_set;
  } stage_t;

  typedef struct packed {
    logic valid;
    logic last;
    px_t  even_px;
    px_t  odd_px;
  } result_t;

  // compare-exchange: smaller value ends up at lane a
  function automatic set9_t cx(set9_t v, lane_t a, lane_t b);
    set9_t r;
    r = v;
    if (v[a] > v[b]) begin
      r[a] = v[b];
      r[b] = v[a];
    end
    return r;
  endfunction

  // one layer of the 19-exchange median-of-9 network; med_tail is the final min
  function automatic set9_t cx_layer(set9_t v, lane_t lyr);
    set9_t r;
    case (lyr)
      4'd1:    r = cx(cx(cx(v, 4'd1, 4'd2), 4'd4, 4'd5), 4'd7, 4'd8);
      4'd2:    r = cx(cx(cx(v, 4'd0, 4'd1), 4'd3, 4'd4), 4'd6, 4'd7);
      4'd3:    r = cx(cx(cx(v, 4'd1, 4'd2), 4'd4, 4'd5), 4'd7, 4'd8);
      4'd4:    r = cx(cx(cx(v, 4'd0, 4'd3), 4'd5, 4'd8), 4'd4, 4'd7);
      4'd5:    r = cx(cx(cx(v, 4'd3, 4'd6), 4'd1, 4'd4), 4'd2, 4'd5);
      4'd6:    r = cx(v, 4'd4, 4'd7);
      4'd7:    r = cx(v, 4'd4, 4'd2);
      4'd8:    r = cx(v, 4'd6, 4'd4);
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic px_t med_tail(set9_t v);
    return (v[4] > v[2]) ? v[2] : v[4];
  endfunction

endpackage

// ===== hw/rtl/smed_ctrl.sv =====
// Frame sequencing: item filtering, raster counters and per-slot border flags.
module smed_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_fire_i,
  input  smed_pkg::cmd_e             cmd_i,
  input  logic [smed_pkg::ROWS_W-1:0] image_rows_i,
  input  logic                       leave_last_i,
  output smed_pkg::ctrl_t            ctrl_o
);
  import smed_pkg::*;

  mode_e mode_q, mode_d;
  logic [ROWS_W-1:0] frame_rows_q, frame_rows_d;
  logic [ROWS_W-1:0] in_row_q, in_row_d, c_row_q, c_row_d;
  logic [COL_W-1:0]  in_col_q, in_col_d, c_col_q, c_col_d;

  logic              starting, expecting, ignore, primed, create, edge_row;
  logic [ROWS_W-1:0] rows_eff, in_row_e, c_row_e;
  logic [COL_W-1:0]  in_col_e, c_col_e;

  function automatic logic [ROWS_W-1:0] clamp_rows(logic [ROWS_W-1:0] r);
    if (r < ROWS_MIN) begin
      return ROWS_MIN;
    end else if (r > ROWS_MAX) begin
      return ROWS_MAX;
    end
    return r;
  endfunction

  always_comb begin : next_mode
    mode_d = mode_q;
    if (ctrl_o.step && leave_last_i) begin
      mode_d = MODE_WAIT;
    end else if (ctrl_o.step && starting) begin
      mode_d = MODE_RUN;
    end
  end

  always_comb begin : outputs
    starting  = (mode_q == MODE_WAIT) && (cmd_i == CMD_PIXELS);
    rows_eff  = starting ? clamp_rows(image_rows_i) : frame_rows_q;
    in_row_e  = starting ? '0 : in_row_q;
    in_col_e  = starting ? '0 : in_col_q;
    c_row_e   = starting ? '0 : c_row_q;
    c_col_e   = starting ? '0 : c_col_q;
    expecting = in_row_e < rows_eff;
    ignore    = (cmd_i == CMD_FLUSH) && ((mode_q == MODE_WAIT) || expecting);
    // window of the centre pair is complete once HALF_WIDTH+1 items are in
    primed    = (in_row_e > ROWS_W'(1)) || ((in_row_e == ROWS_W'(1)) && (in_col_e != '0));
    create    = primed && (c_row_e < rows_eff);
    edge_row  = (c_row_e == '0) || (c_row_e == rows_eff - ROWS_W'(1));

    ctrl_o.step           = in_fire_i && !ignore;
    ctrl_o.flush          = !expecting;
    ctrl_o.slot.valid     = create;
    ctrl_o.slot.last      = create && (c_row_e == rows_eff - ROWS_W'(1)) && (c_col_e == COL_LAST);
    ctrl_o.slot.pass_even = edge_row || (c_col_e == '0);
    ctrl_o.slot.pass_odd  = edge_row || (c_col_e == COL_LAST);

    in_row_d     = in_row_q;
    in_col_d     = in_col_q;
    c_row_d      = c_row_q;
    c_col_d      = c_col_q;
    frame_rows_d = frame_rows_q;
    if (ctrl_o.step) begin
      frame_rows_d = rows_eff;
      if (in_col_e == COL_LAST) begin
        in_col_d = '0;
        in_row_d = in_row_e + ROWS_W'(1);
      end else begin
        in_col_d = in_col_e + COL_W'(1);
        in_row_d = in_row_e;
      end
      if (create && (c_col_e == COL_LAST)) begin
        c_col_d = '0;
        c_row_d = c_row_e + ROWS_W'(1);
      end else if (create) begin
        c_col_d = c_col_e + COL_W'(1);
        c_row_d = c_row_e;
      end else begin
        c_col_d = c_col_e;
        c_row_d = c_row_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_WAIT;
      frame_rows_q <= ROWS_MIN;
      in_row_q     <= '0;
      in_col_q     <= '0;
      c_row_q      <= '0;
      c_col_q      <= '0;
    end else begin
      mode_q       <= mode_d;
      frame_rows_q <= frame_rows_d;
      in_row_q     <= in_row_d;
      in_col_q     <= in_col_d;
      c_row_q      <= c_row_d;
      c_col_q      <= c_col_d;
    end
  end

endmodule

// ===== hw/rtl/smed_window.sv =====
// Line store memory and 3x4 pixel window.
module smed_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                flush_i,
  input  smed_pkg::px_t       pix_even_i,
  input  smed_pkg::px_t       pix_odd_i,
  output smed_pkg::win_t      win_o
);
  import smed_pkg::*;

  // one word per pair column: upper row pair in the low half, middle row pair above
  logic [4*PX_W-1:0] line_mem [LINE_DEPTH];
  logic [4*PX_W-1:0] rd_q;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  win_t              win_q, win_d;
  px_t               px_e, px_o;

  always_comb begin
    px_e  = flush_i ? '0 : pix_even_i;
    px_o  = flush_i ? '0 : pix_odd_i;
    ptr_d = ptr_q;
    if (step_i) begin
      ptr_d = (ptr_q == PTR_W'(LINE_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);
    end
    win_d[0]  = win_q[2];
    win_d[1]  = win_q[3];
    win_d[2]  = rd_q[PX_W-1:0];
    win_d[3]  = rd_q[2*PX_W-1:PX_W];
    win_d[4]  = win_q[6];
    win_d[5]  = win_q[7];
    win_d[6]  = rd_q[3*PX_W-1:2*PX_W];
    win_d[7]  = rd_q[4*PX_W-1:3*PX_W];
    win_d[8]  = win_q[10];
    win_d[9]  = win_q[11];
    win_d[10] = px_e;
    win_d[11] = px_o;
  end

  assign win_o = win_d;

  // read runs one entry ahead, so the write at ptr_q never meets the read address
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      line_mem[ptr_q] <= {win_q[9], win_q[8], win_q[5], win_q[4]};
    end
    rd_q <= line_mem[ptr_d];
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

endmodule

// ===== hw/rtl/smed_pipe.sv =====
// Ten-slot median net: a window slot, then one exchange layer per slot; moves on step.
module smed_pipe (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  smed_pkg::slot_ctl_t  slot_i,
  input  smed_pkg::win_t       win_i,
  output smed_pkg::result_t    leave_o
);
  import smed_pkg::*;

  slot_ctl_t ctl_q [NET_LAYERS+1];
  stage_t    st_q  [NET_LAYERS+1];
  stage_t    st_n  [NET_LAYERS+1];
  logic      fin_valid_q, fin_last_q;
  px_t       fin_even_q, fin_odd_q;
  px_t       held_q;

  always_comb begin
    st_n[0].even_pass = win_i[4];
    st_n[0].odd_pass  = win_i[5];
    st_n[0].odd_set   = {win_i[10], win_i[9], win_i[8], win_i[6], win_i[5],
                         win_i[4], win_i[2], win_i[1], win_i[0]};
    st_n[0].even_set  = {win_i[11], win_i[10], win_i[9], win_i[7], win_i[6],
                         win_i[5], win_i[3], win_i[2], win_i[1]};
  end

  for (genvar i = 1; i <= NET_LAYERS; i++) begin : g_layer
    always_comb begin
      st_n[i].even_pass = st_q[i-1].even_pass;
      st_n[i].odd_pass  = st_q[i-1].odd_pass;
      st_n[i].odd_set   = cx_layer(st_q[i-1].odd_set, lane_t'(i));
      st_n[i].even_set  = cx_layer(st_q[i-1].even_set, lane_t'(i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      for (int i = 0; i <= NET_LAYERS; i++) begin
        st_q[i] <= st_n[i];
      end
      // even median of a window belongs to the pair that follows it
      held_q     <= med_tail(st_q[NET_LAYERS].even_set);
      fin_even_q <= ctl_q[NET_LAYERS].pass_even ? st_q[NET_LAYERS].even_pass : held_q;
      fin_odd_q  <= ctl_q[NET_LAYERS].pass_odd  ? st_q[NET_LAYERS].odd_pass
                                                : med_tail(st_q[NET_LAYERS].odd_set);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NET_LAYERS; i++) begin
        ctl_q[i] <= '0;
      end
      fin_valid_q <= 1'b0;
      fin_last_q  <= 1'b0;
    end else if (step_i) begin
      ctl_q[0] <= slot_i;
      for (int i = 1; i <= NET_LAYERS; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
      fin_valid_q <= ctl_q[NET_LAYERS].valid;
      fin_last_q  <= ctl_q[NET_LAYERS].last;
    end
  end

  assign leave_o = {fin_valid_q, fin_last_q, fin_even_q, fin_odd_q};

endmodule

// ===== hw/rtl/stream_median_3x3_two_pixel_unit.sv =====
// Top level of the streaming 3x3 median filter, two pixels per item.
//
//  channel  | direction | signals                               | payload
//  ---------+-----------+---------------------------------------+------------------------------
//  s_axis   | in        | tvalid / tready / tdata / tuser       | pixel pair, cmd in tuser
//  m_axis   | out       | tvalid / tready / tdata / tlast       | median pair, last pair of frame
//  cfg      | in        | cfg_valid / cfg_ready / cfg_data      | image_rows (rows per frame)
//
// Cycles: one item per clock when m_axis keeps up; every step is a single
//   read-modify-write of the line store, read prefetched one entry ahead.
// Flow: a pair leaves once the item that completes its window, which arrives
//   after the pair itself, has stepped through every network slot. Flush items
//   after the last pixel pair of a frame drain its remaining pairs.
// Stalls: s_axis_tready_o drops only while the output register is full and
//   not taken. Reset clears control only; line store contents are don't-care
//   since they only reach border pixels, which pass through unchanged.
module stream_median_3x3_two_pixel_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [2*smed_pkg::PX_W-1:0] s_axis_tdata_i,   // pixel_even, pixel_odd
  input  logic                        s_axis_tuser_i,   // cmd
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [2*smed_pkg::PX_W-1:0] m_axis_tdata_o,   // median_even, median_odd
  output logic                        m_axis_tlast_o,   // last_pair
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [smed_pkg::ROWS_W-1:0] cfg_data_i        // image_rows
);
  import smed_pkg::*;

  logic              in_fire;
  logic [ROWS_W-1:0] image_rows_q;
  ctrl_t             ctrl;
  win_t              win;
  result_t           leave;

  logic              m_valid_q, m_valid_d;
  logic              m_last_q;
  logic [2*PX_W-1:0] m_data_q;

  assign cfg_ready_o     = 1'b1;
  // output register parts the two sides: take a new item whenever it can drain
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q <= ROWS_RESET;
    end else if (cfg_valid_i) begin
      image_rows_q <= cfg_data_i;
    end
  end

  smed_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .cmd_i        (cmd_e'(s_axis_tuser_i)),
    .image_rows_i (image_rows_q),
    .leave_last_i (leave.valid && leave.last),
    .ctrl_o       (ctrl)
  );

  smed_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (ctrl.step),
    .flush_i    (ctrl.flush),
    .pix_even_i (s_axis_tdata_i[PX_W-1:0]),
    .pix_odd_i  (s_axis_tdata_i[2*PX_W-1:PX_W]),
    .win_o      (win)
  );

  smed_pipe u_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (ctrl.step),
    .slot_i  (ctrl.slot),
    .win_i   (win),
    .leave_o (leave)
  );

  // the slot leaving the network on a step is loaded into the output register
  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready_i;
    if (ctrl.step && leave.valid) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.step && leave.valid) begin
      m_data_q <= {leave.odd_px, leave.even_px};
      m_last_q <= leave.last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // a full, stalled output register must block the input
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while output register is stalled");

  // network only advances on an accepted item
  a_step_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step |-> (s_axis_tvalid_i && s_axis_tready_o))
    else $error("step without an accepted item");

  // a leaving slot is presented on the next cycle
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.step && leave.valid) |=> m_axis_tvalid_o)
    else $error("leaving slot not presented");

endmodule
